@@ design/sshb_pkg.sv @@
// shared constants, types and helpers for the selectable string hash bucket core
`default_nettype none
package sshb_pkg;

    localparam int HASH_WIDTH_DEF = 64;
    localparam int KEY_W          = 8;
    localparam int TSIZE_W        = 32;
    localparam int SEL_W          = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 2'd1;

    localparam logic [SEL_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [SEL_W-1:0] MODE_DJB2 = 3'd2;
    localparam logic [SEL_W-1:0] MODE_SDBM = 3'd3;
    localparam logic [SEL_W-1:0] MODE_ROT  = 3'd4;

    localparam logic [SEL_W-1:0]   SEL_RESET   = MODE_DJB2;
    localparam logic [TSIZE_W-1:0] TSIZE_RESET = 32'd16;
    localparam int                 DJB2_START  = 5381;

    // controller to datapath
    typedef struct packed {
        logic hash_upd;
        logic key_end;
        logic div_step;
        logic out_load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic byte_zero;
        logic div_last;
    } t_dp_status;

    // undefined selector values fall back to djb2
    function automatic logic [SEL_W-1:0] mode_of(input logic [SEL_W-1:0] sel);
        logic [SEL_W-1:0] m;
        case (sel)
            MODE_ADD:  m = MODE_ADD;
            MODE_DJB2: m = MODE_DJB2;
            MODE_SDBM: m = MODE_SDBM;
            MODE_ROT:  m = MODE_ROT;
            default:   m = MODE_DJB2;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ design/selectable_string_hash_bucket_core.sv @@
// Selectable string hash bucket core. Key bytes arrive one per transaction on the key
// channel; a zero byte ends the key. Non-zero bytes are folded into a HASH_WIDTH-bit
// running hash (additive, djb2, sdbm or rotate-xor, picked by the hash_select register,
// index 0) at one byte per cycle. The terminator starts a bit-serial restoring modulo
// by table_size (register index 1), one dividend bit per cycle, so a terminator holds
// the key channel while the modulo runs and through the done state before the next
// byte is taken, and longer while the previous bucket index still waits in the output
// register; the bucket index then sits in the output register until taken, while the
// key channel already accepts the next key. A table_size of zero yields bucket 0.
// Configuration writes take effect from the next byte, so a key may change mode part
// way through; table_size is sampled when the terminator is taken.
`default_nettype none
module selectable_string_hash_bucket_core #(
    parameter int HASH_WIDTH = sshb_pkg::HASH_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [sshb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sshb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                               i_key_valid,
    output logic                                    o_key_ready,
    input  wire logic [sshb_pkg::KEY_W-1:0]         i_key_byte,
    output logic                                    o_bucket_valid,
    input  wire logic                               i_bucket_ready,
    output logic      [sshb_pkg::TSIZE_W-1:0]       o_bucket_index
);

    sshb_pkg::t_ctrl_cmd  cmd;
    sshb_pkg::t_dp_status status;

    sshb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key_valid    (i_key_valid),
        .o_key_ready    (o_key_ready),
        .o_bucket_valid (o_bucket_valid),
        .i_bucket_ready (i_bucket_ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    sshb_datapath #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_key_byte     (i_key_byte),
        .o_bucket_index (o_bucket_index),
        .i_cmd          (cmd),
        .o_status       (status)
    );

endmodule
`default_nettype wire

@@ design/sshb_ctrl.sv @@
// controller state machine: byte intake, modulo sequencing, result handoff
`default_nettype none
module sshb_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_key_valid,
    output logic                       o_key_ready,
    output logic                       o_bucket_valid,
    input  wire logic                  i_bucket_ready,
    input  wire sshb_pkg::t_dp_status  i_status,
    output sshb_pkg::t_ctrl_cmd        o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   key_acc;
    logic   out_free;

    assign o_key_ready    = (r_state == S_IDLE);
    assign o_bucket_valid = r_out_valid;
    assign key_acc        = i_key_valid & o_key_ready;
    // output register is free when empty or being emptied this cycle
    assign out_free       = ~r_out_valid | i_bucket_ready;

    always_comb begin
        o_cmd.hash_upd = key_acc & ~i_status.byte_zero;
        o_cmd.key_end  = key_acc & i_status.byte_zero;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_DONE) & out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (key_acc && i_status.byte_zero) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_bucket_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

@@ design/sshb_datapath.sv @@
// datapath: config registers, running hash, bit-serial modulo, result register
`default_nettype none
module sshb_datapath #(
    parameter int HASH_WIDTH = sshb_pkg::HASH_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [sshb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sshb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic [sshb_pkg::KEY_W-1:0]         i_key_byte,
    output logic      [sshb_pkg::TSIZE_W-1:0]       o_bucket_index,
    input  wire sshb_pkg::t_ctrl_cmd                i_cmd,
    output sshb_pkg::t_dp_status                    o_status
);

    localparam int HW = HASH_WIDTH;
    localparam int TW = sshb_pkg::TSIZE_W;
    localparam int CW = $clog2(HW + 1);
    localparam logic [HW-1:0] START_DJB2 = HW'(sshb_pkg::DJB2_START);

    logic [sshb_pkg::SEL_W-1:0] r_hash_sel;
    logic [TW-1:0]              r_table_size;
    logic [HW-1:0]              r_hash;
    logic                       r_key_open;
    logic [HW-1:0]              r_dividend;
    logic [TW-1:0]              r_rem;
    logic [TW-1:0]              r_divisor;
    logic                       r_div_zero;
    logic [CW-1:0]              r_cnt;
    logic [TW-1:0]              r_result;

    logic [sshb_pkg::SEL_W-1:0] mode;
    logic [HW-1:0]              h_cur;
    logic [HW-1:0]              c_ext;
    logic [HW-1:0]              h_fold;
    logic [TW:0]                trial;
    logic [TW:0]                trial_sub;

    assign mode  = sshb_pkg::mode_of(r_hash_sel);
    // first byte of a key starts from the mode's start value
    assign h_cur = r_key_open ? r_hash :
                   ((mode == sshb_pkg::MODE_DJB2) ? START_DJB2 : '0);
    // signed char extension
    assign c_ext = {{(HW-sshb_pkg::KEY_W){i_key_byte[sshb_pkg::KEY_W-1]}}, i_key_byte};

    always_comb begin
        case (mode)
            sshb_pkg::MODE_ADD:  h_fold = h_cur + c_ext;
            sshb_pkg::MODE_SDBM: h_fold = c_ext + (h_cur << 6) + (h_cur << 16) - h_cur;
            sshb_pkg::MODE_ROT:  h_fold = (h_cur << 4) ^ (h_cur >> 28) ^ c_ext;
            default:             h_fold = (h_cur << 5) + h_cur + c_ext;
        endcase
    end

    // restoring division step, one dividend bit per cycle
    assign trial     = {r_rem, r_dividend[HW-1]};
    assign trial_sub = trial - {1'b0, r_divisor};

    assign o_status.byte_zero = (i_key_byte == '0);
    assign o_status.div_last  = (r_cnt == CW'(1));
    assign o_bucket_index     = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_sel   <= sshb_pkg::SEL_RESET;
            r_table_size <= sshb_pkg::TSIZE_RESET;
            r_hash       <= START_DJB2;
            r_key_open   <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sshb_pkg::CFG_HASH_SELECT: r_hash_sel <= i_cfg_wdata[sshb_pkg::SEL_W-1:0];
                    sshb_pkg::CFG_TABLE_SIZE:  r_table_size <= i_cfg_wdata[TW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.hash_upd) begin
                r_hash     <= h_fold;
                r_key_open <= 1'b1;
            end else if (i_cmd.key_end) begin
                r_hash     <= START_DJB2;
                r_key_open <= 1'b0;
            end
            if (i_cmd.key_end) begin
                r_cnt <= CW'(HW);
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_end) begin
            r_dividend <= h_cur;
            r_rem      <= '0;
            r_divisor  <= r_table_size;
            r_div_zero <= (r_table_size == '0);
        end else if (i_cmd.div_step) begin
            r_dividend <= r_dividend << 1;
            if (!trial_sub[TW]) begin
                r_rem <= trial_sub[TW-1:0];
            end else begin
                r_rem <= trial[TW-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_result <= r_div_zero ? '0 : r_rem;
        end
    end

endmodule
`default_nettype wire
